### rtl/b2da_pkg.sv
// ----------------------------------------------------------------------------
// b2da_pkg - shared types and constants
// Field widths, digit layout and the handover record between the
// double-dabble core and the digit emitter.
// ----------------------------------------------------------------------------
package b2da_pkg;

  localparam int VALUE_W  = 32;               // binary input width
  localparam int NDIG     = 10;               // decimal digits of a 32-bit value
  localparam int CHAR_W   = 6;                // ASCII digit width on the port
  localparam int COUNT_W  = 4;                // digit count width
  localparam int STEP_W   = $clog2(VALUE_W);  // shift step counter

  localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

  // BCD word, digit 0 least significant
  typedef logic [NDIG-1:0][3:0] bcd_t;

  // core -> emitter handover
  typedef struct packed {
    logic valid;
    bcd_t bcd;
  } conv_t;

endpackage

### rtl/binary_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii - 32-bit unsigned to decimal ASCII text
// Double-dabble conversion followed by serial digit output.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid / in_ready / in_value): one 32-bit unsigned
//   value per request. in_ready is high only while the shift-add-3 core
//   is idle.
//   Output channel (out_valid / out_ready / out_*): one request per decimal
//   digit, most significant first, no leading zeros; zero gives a single
//   '0'. Each carries the ASCII digit, the item's digit count (1 to 10)
//   and out_last on the least significant digit.
//   Timing: the core shifts one input bit per cycle, then hands the BCD
//   word to the emitter, which loads the output register with the first
//   digit. Digits then leave one per cycle while out_ready is high. The
//   core converts the next value while the emitter drains.
//   Reset (rst_n low, synchronous) empties core, emitter and output
//   register. A stalled receiver holds the current digit; the emitter
//   waits, then the core, then the input.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [b2da_pkg::VALUE_W-1:0] in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [b2da_pkg::CHAR_W-1:0]  out_digit_char,
  output logic [b2da_pkg::COUNT_W-1:0] out_digit_count,
  output logic                         out_last
);
  import b2da_pkg::*;

  // BCD handover, held by the core until the emitter is free
  conv_t conv;
  logic  take;

  // bit-serial binary to BCD
  b2da_dabble u_dabble (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_value (in_value),
    .res      (conv),
    .take     (take)
  );

  // digit sizing and serial ASCII output
  b2da_emit u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .conv            (conv),
    .take            (take),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digit_char  (out_digit_char),
    .out_digit_count (out_digit_count),
    .out_last        (out_last)
  );

endmodule

### rtl/b2da_dabble.sv
// ----------------------------------------------------------------------------
// b2da_dabble - shift-add-3 binary to BCD core
// One input bit per cycle; the BCD result is held until the emitter
// takes it.
// ----------------------------------------------------------------------------
module b2da_dabble (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [b2da_pkg::VALUE_W-1:0] in_value,
  output b2da_pkg::conv_t              res,
  input  logic                         take
);
  import b2da_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(VALUE_W - 1);

  logic [1:0]         state_r, state_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [VALUE_W-1:0] bin_r, bin_nxt;
  bcd_t               bcd_r, bcd_nxt;
  bcd_t               bcd_adj;

  // add 3 to every digit of 5 or more ahead of the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      bcd_adj[i] = (bcd_r[i] >= 4'd5) ? bcd_r[i] + 4'd3 : bcd_r[i];
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign res.valid = (state_r == ST_DONE);
  assign res.bcd   = bcd_r;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    bin_nxt   = bin_r;
    bcd_nxt   = bcd_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          bin_nxt   = in_value;
          bcd_nxt   = '0;
          step_nxt  = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        {bcd_nxt, bin_nxt} = {bcd_adj[NDIG-1:0], bin_r} << 1;
        step_nxt = step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

`ifndef SYNTH
  a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_RUN && step_r == '0))
    else $error("accepted request did not start conversion");
  a_last_step_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && step_r == LAST_STEP) |=> res.valid)
    else $error("conversion did not finish after final shift");
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && !take) |=> (res.valid && $stable(res.bcd)))
    else $error("BCD result lost before handover");
`endif

endmodule

### rtl/b2da_emit.sv
// ----------------------------------------------------------------------------
// b2da_emit - digit emitter
// Sizes the BCD word, then sends one ASCII digit per request, most
// significant first, through a registered output.
// ----------------------------------------------------------------------------
module b2da_emit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  b2da_pkg::conv_t              conv,
  output logic                         take,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [b2da_pkg::CHAR_W-1:0]  out_digit_char,
  output logic [b2da_pkg::COUNT_W-1:0] out_digit_count,
  output logic                         out_last
);
  import b2da_pkg::*;

  // digit count of a BCD word, one digit at least
  function automatic logic [COUNT_W-1:0] num_digits(bcd_t b);
    logic [COUNT_W-1:0] n;
    n = COUNT_W'(1);
    for (int i = 1; i < NDIG; i++) begin
      if (b[i] != 4'd0) n = COUNT_W'(i + 1);
    end
    return n;
  endfunction

  logic               busy_r;
  bcd_t               bcd_r;
  logic [COUNT_W-1:0] n_r;
  logic [COUNT_W-1:0] idx_r;
  logic [COUNT_W-1:0] n_new;
  logic               out_valid_r;
  logic [CHAR_W-1:0]  char_r;
  logic [COUNT_W-1:0] count_r;
  logic               last_r;
  logic               out_free;
  logic               send;

  assign n_new    = num_digits(conv.bcd);
  assign take     = conv.valid && !busy_r;
  assign out_free = !out_valid_r || out_ready;
  assign send     = busy_r && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        busy_r <= 1'b1;
      end else if (send && idx_r == '0) begin
        busy_r <= 1'b0;
      end
      if (send) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      bcd_r <= conv.bcd;
      n_r   <= n_new;
      idx_r <= n_new - 1'b1;
    end else if (send) begin
      idx_r <= idx_r - 1'b1;
    end
    if (send) begin
      char_r  <= ASCII_ZERO + CHAR_W'(bcd_r[idx_r]);
      count_r <= n_r;
      last_r  <= (idx_r == '0);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_digit_char  = char_r;
  assign out_digit_count = count_r;
  assign out_last        = last_r;

`ifndef SYNTH
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (idx_r < n_r))
    else $error("digit index beyond digit count");
  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> (busy_r && out_valid_r == $past(out_valid_r && !out_ready)))
    else $error("emitter did not start on handover");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (send && idx_r == '0) |=> (out_last && !busy_r))
    else $error("run did not end on its final digit");
`endif

endmodule
